>>> sv/stbq_pkg.sv
`default_nettype none

package stbq_pkg;

    localparam int unsigned SampleWidth   = 16;
    localparam int unsigned CoefWidth     = 21;
    localparam int unsigned CoefFracBits  = 17;
    localparam int unsigned StateFracBits = 16;
    localparam int unsigned StateWidth    = 40;
    localparam int unsigned ProdFullWidth = CoefWidth + StateWidth;
    localparam int unsigned ProdWidth     = ProdFullWidth - CoefFracBits;
    localparam int unsigned AccWidth      = 48;
    localparam int unsigned ChannelCount  = 2;
    localparam int unsigned FfWidth       = 3 * CoefWidth;
    localparam int unsigned FbWidth       = 2 * CoefWidth;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = FfWidth;
    localparam int unsigned PcWidth       = 4;

    localparam logic [FfWidth-1:0] FfReset = FfWidth'(1) << (2 * CoefWidth + CoefFracBits);
    localparam logic [FbWidth-1:0] FbReset = '0;

    localparam logic [PcWidth-1:0] StepFirst = PcWidth'(0);

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_FILTER_ENABLE     = 3'd0,
        REG_STEREO_MODE       = 3'd1,
        REG_SHELF_FEEDFORWARD = 3'd2,
        REG_SHELF_FEEDBACK    = 3'd3,
        REG_PEAK_FEEDFORWARD  = 3'd4,
        REG_PEAK_FEEDBACK     = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic {
        SRC_X = 1'b0,
        SRC_Y = 1'b1
    } mul_src_t;

    typedef enum logic [2:0] {
        ACC_HOLD    = 3'd0,
        ACC_P_D1    = 3'd1,
        ACC_P_D2    = 3'd2,
        ACC_LOAD_P  = 3'd3,
        ACC_SUB_P   = 3'd4
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT = 2'd0,
        JMP_LOOP = 2'd1,
        JMP_OUT  = 2'd2
    } jmp_t;

    typedef struct packed {
        coef_sel_t coef;
        mul_src_t  src;
        acc_op_t   acc;
        logic      wr_y;
        logic      wr_d1;
        logic      wr_d2;
        logic      wr_x;
        jmp_t      jmp;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   run;
        logic   load_x;
        logic   stage;
        logic   ch;
    } dp_ctrl_t;

    // One biquad per pass (shelf, then peak); the last step hands off the result.
    function automatic uword_t ucode(input logic [PcWidth-1:0] pc);
        uword_t w;
        w = '{coef: COEF_B0, src: SRC_X, acc: ACC_HOLD, wr_y: 1'b0, wr_d1: 1'b0,
              wr_d2: 1'b0, wr_x: 1'b0, jmp: JMP_NEXT};
        unique case (pc)
            4'd0: w.coef = COEF_B0;
            4'd1: w.acc = ACC_P_D1;
            4'd2:
            begin
                w.wr_y = 1'b1;
                w.coef = COEF_B1;
            end
            4'd3:
            begin
                w.acc  = ACC_P_D2;
                w.coef = COEF_A1;
                w.src  = SRC_Y;
            end
            4'd4:
            begin
                w.acc  = ACC_SUB_P;
                w.coef = COEF_B2;
            end
            4'd5:
            begin
                w.wr_d1 = 1'b1;
                w.acc   = ACC_LOAD_P;
                w.coef  = COEF_A2;
                w.src   = SRC_Y;
            end
            4'd6: w.acc = ACC_SUB_P;
            4'd7:
            begin
                w.wr_d2 = 1'b1;
                w.wr_x  = 1'b1;
                w.jmp   = JMP_LOOP;
            end
            default: w.jmp = JMP_OUT;
        endcase
        return w;
    endfunction

    function automatic logic signed [StateWidth-1:0] sat40(
        input logic signed [AccWidth-1:0] v
    );
        logic [AccWidth-StateWidth:0] top;
        top = v[AccWidth-1:StateWidth-1];
        if ((&top) || !(|top))
            return v[StateWidth-1:0];
        else if (v[AccWidth-1])
            return {1'b1, {(StateWidth-1){1'b0}}};
        else
            return {1'b0, {(StateWidth-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

>>> sv/stbq_datapath.sv
`default_nettype none

module stbq_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire stbq_pkg::dp_ctrl_t                    ctrl,
    input  wire logic signed [stbq_pkg::SampleWidth-1:0] sample,
    input  wire logic [stbq_pkg::FfWidth-1:0]          shelf_ff,
    input  wire logic [stbq_pkg::FbWidth-1:0]          shelf_fb,
    input  wire logic [stbq_pkg::FfWidth-1:0]          peak_ff,
    input  wire logic [stbq_pkg::FbWidth-1:0]          peak_fb,
    output logic signed [stbq_pkg::SampleWidth-1:0]    result,
    output logic                                       clip
);

    localparam int unsigned CW = stbq_pkg::CoefWidth;
    localparam int unsigned SW = stbq_pkg::StateWidth;
    localparam int unsigned AW = stbq_pkg::AccWidth;
    localparam int unsigned SF = stbq_pkg::StateFracBits;
    localparam int unsigned QW = SW - SF;
    localparam logic signed [SW-1:0] OutTop = SW'(32767) <<< SF;
    localparam logic signed [SW-1:0] OutBot = -(SW'(32768) <<< SF);
    localparam logic signed [stbq_pkg::ProdFullWidth-1:0] RoundHalf =
        stbq_pkg::ProdFullWidth'(1) <<< (stbq_pkg::CoefFracBits - 1);

    logic signed [SW-1:0] x_reg;
    logic signed [SW-1:0] y_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [stbq_pkg::ProdWidth-1:0] prod_reg;
    logic signed [SW-1:0] d1_reg [0:1][0:stbq_pkg::ChannelCount-1];
    logic signed [SW-1:0] d2_reg [0:1][0:stbq_pkg::ChannelCount-1];

    logic [stbq_pkg::FfWidth-1:0] ff;
    logic [stbq_pkg::FbWidth-1:0] fb;
    logic signed [CW-1:0] coef;
    logic signed [SW-1:0] opnd;
    logic signed [stbq_pkg::ProdFullWidth-1:0] prod_full;
    logic signed [stbq_pkg::ProdFullWidth-1:0] prod_rnd;
    logic signed [SW-1:0] d1_cur;
    logic signed [SW-1:0] d2_cur;
    logic signed [SW-1:0] acc_sat;
    logic signed [QW-1:0] q;
    logic [SF-1:0] frac;
    logic round_up;
    logic above;
    logic below;

    assign ff = ctrl.stage ? peak_ff : shelf_ff;
    assign fb = ctrl.stage ? peak_fb : shelf_fb;

    always_comb
    begin
        unique case (ctrl.uw.coef)
            stbq_pkg::COEF_B0: coef = ff[3*CW-1:2*CW];
            stbq_pkg::COEF_B1: coef = ff[2*CW-1:CW];
            stbq_pkg::COEF_B2: coef = ff[CW-1:0];
            stbq_pkg::COEF_A1: coef = fb[2*CW-1:CW];
            stbq_pkg::COEF_A2: coef = fb[CW-1:0];
            default:           coef = '0;
        endcase
    end

    assign opnd      = (ctrl.uw.src == stbq_pkg::SRC_Y) ? y_reg : x_reg;
    assign prod_full = coef * opnd;
    assign prod_rnd  = prod_full + RoundHalf;

    assign d1_cur  = d1_reg[ctrl.stage][ctrl.ch];
    assign d2_cur  = d2_reg[ctrl.stage][ctrl.ch];
    assign acc_sat = stbq_pkg::sat40(acc_reg);

    always_comb
    begin
        unique case (ctrl.uw.acc)
            stbq_pkg::ACC_HOLD:   acc_next = acc_reg;
            stbq_pkg::ACC_P_D1:   acc_next = AW'(prod_reg) + AW'(d1_cur);
            stbq_pkg::ACC_P_D2:   acc_next = AW'(prod_reg) + AW'(d2_cur);
            stbq_pkg::ACC_LOAD_P: acc_next = AW'(prod_reg);
            stbq_pkg::ACC_SUB_P:  acc_next = acc_reg - AW'(prod_reg);
            default:              acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_rnd[stbq_pkg::ProdFullWidth-1:stbq_pkg::CoefFracBits];
        if (ctrl.run)
            acc_reg <= acc_next;
        if (ctrl.run && ctrl.uw.wr_y)
            y_reg <= acc_sat;
        if (ctrl.load_x)
            x_reg <= {{(SW - stbq_pkg::SampleWidth - SF){sample[stbq_pkg::SampleWidth-1]}},
                      sample, {SF{1'b0}}};
        else if (ctrl.run && ctrl.uw.wr_x)
            x_reg <= y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
            begin
                for (int c = 0; c < stbq_pkg::ChannelCount; c++)
                begin
                    d1_reg[s][c] <= '0;
                    d2_reg[s][c] <= '0;
                end
            end
        end
        else
        begin
            if (ctrl.run && ctrl.uw.wr_d1)
                d1_reg[ctrl.stage][ctrl.ch] <= acc_sat;
            if (ctrl.run && ctrl.uw.wr_d2)
                d2_reg[ctrl.stage][ctrl.ch] <= acc_sat;
        end
    end

    // round half to even, saturate to 16 bits
    assign q        = y_reg[SW-1:SF];
    assign frac     = y_reg[SF-1:0];
    assign round_up = frac[SF-1] & ((|frac[SF-2:0]) | q[0]);
    assign above    = y_reg > OutTop;
    assign below    = y_reg < OutBot;

    always_comb
    begin
        clip = above | below;
        priority if (above)
            result = {1'b0, {(stbq_pkg::SampleWidth-1){1'b1}}};
        else if (below)
            result = {1'b1, {(stbq_pkg::SampleWidth-1){1'b0}}};
        else
            result = q[stbq_pkg::SampleWidth-1:0]
                   + {{(stbq_pkg::SampleWidth-1){1'b0}}, round_up};
    end

endmodule

`default_nettype wire

>>> sv/stereo_two_biquad_eq.sv
// Stereo two-stage equalizer: low-shelf biquad then peaking biquad per sample.
// Input channel: in_valid/in_stall with sample_in and last_in_buffer; a transfer
// happens on a clock edge with in_valid high and in_stall low. Samples are
// interleaved left, right; last_in_buffer returns the channel to left.
// Output channel: out_valid/out_stall with sample_out and clipped, held stable
// while out_stall is high.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no sample is in flight. Unknown indexes are ignored.
// Filter enabled: the microcode runs 8 steps per biquad on one shared
// 21x40 multiplier, twice, plus one hand-off step; no new sample is taken
// until the hand-off step has passed the result to the output register.
// A sample can be taken while a previous result is still waiting; the hand-off
// step holds until the output register is free.
// Filter disabled: registered pass-through, valid in the next cycle, no new
// sample while the output register is full, delay state untouched.
// Reset clears config to pass-through, stereo mode, unity coefficients, and
// zeroes all delay state and the channel toggle.
`default_nettype none

module stereo_two_biquad_eq (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [stbq_pkg::SampleWidth-1:0] sample_in,
    input  wire logic                                   last_in_buffer,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [stbq_pkg::SampleWidth-1:0]     sample_out,
    output logic                                        clipped,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [stbq_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  wire logic [stbq_pkg::CfgDataWidth-1:0]      cfg_data
);

    logic                               enable_reg;
    logic                               stereo_reg;
    logic [stbq_pkg::FfWidth-1:0]       shelf_ff_reg;
    logic [stbq_pkg::FbWidth-1:0]       shelf_fb_reg;
    logic [stbq_pkg::FfWidth-1:0]       peak_ff_reg;
    logic [stbq_pkg::FbWidth-1:0]       peak_fb_reg;

    logic                               running_reg, running_next;
    logic [stbq_pkg::PcWidth-1:0]       pc_reg, pc_next;
    logic                               stage_reg, stage_next;
    logic                               toggle_reg, toggle_next;
    logic                               ch_reg, ch_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [stbq_pkg::SampleWidth-1:0] sample_out_reg, sample_out_next;
    logic                               clipped_reg, clipped_next;

    logic                               in_xfer;
    logic                               cfg_xfer;
    logic                               out_free;
    stbq_pkg::uword_t                   uw;
    stbq_pkg::dp_ctrl_t                 ctrl;
    logic signed [stbq_pkg::SampleWidth-1:0] filt_sample;
    logic                               filt_clip;

    assign in_stall   = running_reg | (out_valid_reg & ~enable_reg);
    assign in_xfer    = in_valid & ~in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_xfer   = cfg_valid & cfg_ready;
    assign out_free   = ~(out_valid_reg & out_stall);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    assign uw = stbq_pkg::ucode(pc_reg);

    always_comb
    begin
        ctrl.uw     = uw;
        ctrl.run    = running_reg;
        ctrl.load_x = in_xfer & enable_reg;
        ctrl.stage  = stage_reg;
        ctrl.ch     = ch_reg;
    end

    stbq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (sample_in),
        .shelf_ff (shelf_ff_reg),
        .shelf_fb (shelf_fb_reg),
        .peak_ff  (peak_ff_reg),
        .peak_fb  (peak_fb_reg),
        .result   (filt_sample),
        .clip     (filt_clip)
    );

    always_comb
    begin
        running_next    = running_reg;
        pc_next         = pc_reg;
        stage_next      = stage_reg;
        toggle_next     = toggle_reg;
        ch_next         = ch_reg;
        out_valid_next  = out_valid_reg & out_stall;
        sample_out_next = sample_out_reg;
        clipped_next    = clipped_reg;

        if (in_xfer)
        begin
            ch_next     = stereo_reg & toggle_reg;
            toggle_next = stereo_reg & ~last_in_buffer & ~toggle_reg;
            if (enable_reg)
            begin
                running_next = 1'b1;
                pc_next      = stbq_pkg::StepFirst;
                stage_next   = 1'b0;
            end
            else
            begin
                out_valid_next  = 1'b1;
                sample_out_next = sample_in;
                clipped_next    = 1'b0;
            end
        end
        else if (running_reg)
        begin
            unique case (uw.jmp)
                stbq_pkg::JMP_NEXT: pc_next = pc_reg + 1'b1;
                stbq_pkg::JMP_LOOP:
                begin
                    if (!stage_reg)
                    begin
                        stage_next = 1'b1;
                        pc_next    = stbq_pkg::StepFirst;
                    end
                    else
                        pc_next = pc_reg + 1'b1;
                end
                stbq_pkg::JMP_OUT:
                begin
                    if (out_free)
                    begin
                        running_next    = 1'b0;
                        out_valid_next  = 1'b1;
                        sample_out_next = filt_sample;
                        clipped_next    = filt_clip;
                    end
                end
                default: pc_next = pc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            pc_reg        <= stbq_pkg::StepFirst;
            stage_reg     <= 1'b0;
            toggle_reg    <= 1'b0;
            ch_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            enable_reg    <= 1'b0;
            stereo_reg    <= 1'b1;
            shelf_ff_reg  <= stbq_pkg::FfReset;
            shelf_fb_reg  <= stbq_pkg::FbReset;
            peak_ff_reg   <= stbq_pkg::FfReset;
            peak_fb_reg   <= stbq_pkg::FbReset;
        end
        else
        begin
            running_reg   <= running_next;
            pc_reg        <= pc_next;
            stage_reg     <= stage_next;
            toggle_reg    <= toggle_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    stbq_pkg::REG_FILTER_ENABLE:     enable_reg   <= cfg_data[0];
                    stbq_pkg::REG_STEREO_MODE:       stereo_reg   <= cfg_data[0];
                    stbq_pkg::REG_SHELF_FEEDFORWARD: shelf_ff_reg <= cfg_data;
                    stbq_pkg::REG_SHELF_FEEDBACK:
                        shelf_fb_reg <= cfg_data[stbq_pkg::FbWidth-1:0];
                    stbq_pkg::REG_PEAK_FEEDFORWARD:  peak_ff_reg  <= cfg_data;
                    stbq_pkg::REG_PEAK_FEEDBACK:
                        peak_fb_reg <= cfg_data[stbq_pkg::FbWidth-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_out_reg <= sample_out_next;
        clipped_reg    <= clipped_next;
    end

endmodule

`default_nettype wire

>>> tb/tb_stereo_two_biquad_eq.sv
`timescale 1ns / 1ps

import stbq_pkg::*;

typedef struct {
    logic signed [SampleWidth-1:0] sample;
    logic                          clip;
} eq_result_t;

typedef struct {
    logic               enable;
    logic               stereo;
    logic [FfWidth-1:0] shelf_ff;
    logic [FbWidth-1:0] shelf_fb;
    logic [FfWidth-1:0] peak_ff;
    logic [FbWidth-1:0] peak_fb;
} eq_settings_t;

class eq_scoreboard;
    localparam longint StateMax = (longint'(1) <<< (StateWidth - 1)) - 1;
    localparam longint StateMin = -StateMax - 1;
    localparam longint PcmTop   = longint'(32767) <<< StateFracBits;
    localparam longint PcmBot   = -(longint'(32768) <<< StateFracBits);
    localparam longint HalfLsb  = longint'(1) <<< (StateFracBits - 1);

    eq_settings_t cur;
    longint       shelf_d1[ChannelCount];
    longint       shelf_d2[ChannelCount];
    longint       peak_d1[ChannelCount];
    longint       peak_d2[ChannelCount];
    logic         toggle;
    eq_result_t   pending[$];
    int           mismatches;

    function new();
        cur.enable   = 1'b0;
        cur.stereo   = 1'b1;
        cur.shelf_ff = FfReset;
        cur.shelf_fb = FbReset;
        cur.peak_ff  = FfReset;
        cur.peak_fb  = FbReset;
        for (int i = 0; i < ChannelCount; i++)
        begin
            shelf_d1[i] = 0;
            shelf_d2[i] = 0;
            peak_d1[i]  = 0;
            peak_d2[i]  = 0;
        end
        toggle     = 1'b0;
        mismatches = 0;
    endfunction

    function void note_config(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
        case (idx)
            REG_FILTER_ENABLE:     cur.enable   = data[0];
            REG_STEREO_MODE:       cur.stereo   = data[0];
            REG_SHELF_FEEDFORWARD: cur.shelf_ff = data[FfWidth-1:0];
            REG_SHELF_FEEDBACK:    cur.shelf_fb = data[FbWidth-1:0];
            REG_PEAK_FEEDFORWARD:  cur.peak_ff  = data[FfWidth-1:0];
            REG_PEAK_FEEDBACK:     cur.peak_fb  = data[FbWidth-1:0];
            default: ;
        endcase
    endfunction

    function longint coef_at(logic [FfWidth-1:0] word, int lsb);
        logic signed [CoefWidth-1:0] c;
        c = word[lsb +: CoefWidth];
        return longint'(c);
    endfunction

    function longint scaled_product(longint c, longint v);
        longint p;
        p = c * v + (longint'(1) <<< (CoefFracBits - 1));
        return p >>> CoefFracBits;
    endfunction

    function longint clamp_state(longint v);
        if (v > StateMax)
            return StateMax;
        if (v < StateMin)
            return StateMin;
        return v;
    endfunction

    function longint biquad_stage(input logic [FfWidth-1:0] ff, input logic [FfWidth-1:0] fb,
                                  input longint x, inout longint d1, inout longint d2);
        longint y;
        y  = clamp_state(scaled_product(coef_at(ff, 2 * CoefWidth), x) + d1);
        d1 = clamp_state(scaled_product(coef_at(ff, CoefWidth), x)
                         - scaled_product(coef_at(fb, CoefWidth), y) + d2);
        d2 = clamp_state(scaled_product(coef_at(ff, 0), x) - scaled_product(coef_at(fb, 0), y));
        return y;
    endfunction

    function void note_input(logic signed [SampleWidth-1:0] sample, logic last);
        eq_result_t r;
        logic       two;
        int         ch;
        longint     x;
        longint     q;
        longint     frac;
        two      = cur.stereo;
        ch       = two ? int'(toggle) : 0;
        r.sample = sample;
        r.clip   = 1'b0;
        if (cur.enable)
        begin
            x = longint'(sample) <<< StateFracBits;
            x = biquad_stage(cur.shelf_ff, FfWidth'(cur.shelf_fb), x, shelf_d1[ch], shelf_d2[ch]);
            x = biquad_stage(cur.peak_ff, FfWidth'(cur.peak_fb), x, peak_d1[ch], peak_d2[ch]);
            if (x > PcmTop)
            begin
                r.sample = 16'sh7FFF;
                r.clip   = 1'b1;
            end
            else if (x < PcmBot)
            begin
                r.sample = 16'sh8000;
                r.clip   = 1'b1;
            end
            else
            begin
                q    = x >>> StateFracBits;
                frac = x - (q <<< StateFracBits);
                if (frac > HalfLsb || (frac == HalfLsb && q[0]))
                    q = q + 1;
                r.sample = q[SampleWidth-1:0];
            end
        end
        toggle = (two && !last) ? ~toggle : 1'b0;
        pending.push_back(r);
    endfunction

    function void check_result(logic signed [SampleWidth-1:0] sample, logic clip);
        eq_result_t e;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected sample transfer: sample_out=%0d clipped=%0b", sample, clip);
            return;
        end
        e = pending.pop_front();
        if (sample !== e.sample || clip !== e.clip)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                         e.sample, sample, e.clip, clip);
        end
    endfunction
endclass

module tb_stereo_two_biquad_eq;

    localparam logic [CfgIndexWidth-1:0] CfgSpareLow  = 3'd6;
    localparam logic [CfgIndexWidth-1:0] CfgSpareHigh = 3'd7;
    localparam int CycleLimit     = 500000;
    localparam int PhaseItems     = 58;
    localparam int LongHoldCycles = 300;
    localparam int Unity          = 1 << CoefFracBits;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [SampleWidth-1:0]   sample_in;
    logic                            last_in_buffer;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [SampleWidth-1:0]   sample_out;
    logic                            clipped;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [CfgIndexWidth-1:0]        cfg_index;
    logic [CfgDataWidth-1:0]         cfg_data;

    eq_scoreboard sb;
    int           tx_idle_pct;
    int           rx_stall_pct;
    int           hold_requests;
    int           hold_served;
    int           hold_left;
    int           cycle_count;

    stereo_two_biquad_eq DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_in      (sample_in),
        .last_in_buffer (last_in_buffer),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sample_out     (sample_out),
        .clipped        (clipped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [CfgDataWidth-1:0] rand_word();
        return CfgDataWidth'({$urandom(), $urandom()});
    endfunction

    function automatic int rand_coef(int limit);
        return int'($urandom_range(2 * limit)) - limit;
    endfunction

    function automatic logic [FfWidth-1:0] ff_word(int b0, int b1, int b2);
        return {CoefWidth'(b0), CoefWidth'(b1), CoefWidth'(b2)};
    endfunction

    function automatic logic [FbWidth-1:0] fb_word(int a1, int a2);
        return {CoefWidth'(a1), CoefWidth'(a2)};
    endfunction

    function automatic eq_settings_t tame_settings(logic stereo);
        eq_settings_t s;
        s.enable   = 1'b1;
        s.stereo   = stereo;
        s.shelf_ff = ff_word(rand_coef(196608), rand_coef(131072), rand_coef(65536));
        s.shelf_fb = fb_word(rand_coef(65536), rand_coef(52428));
        s.peak_ff  = ff_word(rand_coef(196608), rand_coef(131072), rand_coef(65536));
        s.peak_fb  = fb_word(rand_coef(65536), rand_coef(52428));
        return s;
    endfunction

    function automatic eq_settings_t wild_settings(logic enable, logic stereo);
        eq_settings_t        s;
        logic [FfWidth-1:0] w;
        s.enable   = enable;
        s.stereo   = stereo;
        s.shelf_ff = rand_word();
        w          = rand_word();
        s.shelf_fb = w[FbWidth-1:0];
        s.peak_ff  = rand_word();
        w          = rand_word();
        s.peak_fb  = w[FbWidth-1:0];
        return s;
    endfunction

    function automatic eq_settings_t flat_settings(logic [CoefWidth-1:0] c, logic stereo);
        eq_settings_t s;
        s.enable   = 1'b1;
        s.stereo   = stereo;
        s.shelf_ff = {c, c, c};
        s.shelf_fb = {c, c};
        s.peak_ff  = {c, c, c};
        s.peak_fb  = {c, c};
        return s;
    endfunction

    function automatic logic signed [SampleWidth-1:0] rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return SampleWidth'($urandom());
        if (pick < 85)
            return SampleWidth'(int'($urandom_range(512)) - 256);
        case ($urandom_range(3))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.note_config(idx, data);
    endtask

    // upper bits of the narrow registers carry junk; it must be dropped
    task automatic apply_settings(input eq_settings_t s);
        logic [CfgDataWidth-1:0] junk;
        junk = rand_word();
        write_reg(REG_FILTER_ENABLE, {junk[CfgDataWidth-1:1], s.enable});
        junk = rand_word();
        write_reg(REG_STEREO_MODE, {junk[CfgDataWidth-1:1], s.stereo});
        write_reg(REG_SHELF_FEEDFORWARD, s.shelf_ff);
        junk = rand_word();
        write_reg(REG_SHELF_FEEDBACK, {junk[CfgDataWidth-1:FbWidth], s.shelf_fb});
        write_reg(REG_PEAK_FEEDFORWARD, s.peak_ff);
        junk = rand_word();
        write_reg(REG_PEAK_FEEDBACK, {junk[CfgDataWidth-1:FbWidth], s.peak_fb});
        write_reg($urandom_range(1) ? CfgSpareHigh : CfgSpareLow, rand_word());
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [SampleWidth-1:0] s, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample_in      <= s;
        last_in_buffer <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(s, last);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receive side: random stall plus an occasional long hold-off
    initial
    begin
        out_stall   <= 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(sample_out, clipped);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left   = LongHoldCycles;
            end
            out_stall <= (hold_left > 0) || ($urandom_range(99) < rx_stall_pct);
            if (hold_left > 0)
                hold_left = hold_left - 1;
        end
    end

    initial
    begin
        eq_settings_t cfg;
        int           sent;
        int           len;
        sb             = new();
        cycle_count    = 0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_requests  = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        sample_in      <= '0;
        last_in_buffer <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_FILTER_ENABLE;
        cfg_data       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: pass-through
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b1);
        send_sample(16'sh5555, 1'b0);
        drain();

        // unity coefficients, filter on
        cfg.enable   = 1'b1;
        cfg.stereo   = 1'b1;
        cfg.shelf_ff = FfReset;
        cfg.shelf_fb = FbReset;
        cfg.peak_ff  = FfReset;
        cfg.peak_fb  = FbReset;
        apply_settings(cfg);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh3039, 1'b1);
        drain();

        // half gain: ties round to even
        cfg.shelf_ff = ff_word(Unity / 2, 0, 0);
        apply_settings(cfg);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd5, 1'b1);
        drain();

        // near-max gain: saturation both ways
        cfg.shelf_ff = ff_word(21'h0FFFFF, 0, 0);
        apply_settings(cfg);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd4096, 1'b0);
        send_sample(16'sd4000, 1'b1);
        drain();

        // mono: one delay line shared by all samples
        cfg.stereo   = 1'b0;
        cfg.shelf_ff = ff_word(Unity, Unity / 2, 0);
        apply_settings(cfg);
        send_sample(16'sd1000, 1'b0);
        send_sample(16'sd2000, 1'b0);
        send_sample(16'sd3000, 1'b1);
        send_sample(16'sd4000, 1'b0);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: cfg = tame_settings(1'b1);
                1: cfg = wild_settings(1'b1, 1'($urandom_range(1)));
                2: cfg = flat_settings(21'h0FFFFF, 1'b1);
                3: cfg = tame_settings(1'b0);
                4: cfg = wild_settings(1'b0, 1'b1);
                5: cfg = flat_settings(21'h100000, 1'($urandom_range(1)));
                6: cfg = tame_settings(1'b1);
                7: cfg = flat_settings(21'h1FFFFF, 1'b1);
                8: cfg = flat_settings(21'h000000, 1'b0);
                default: cfg = tame_settings(1'($urandom_range(1)));
            endcase
            apply_settings(cfg);
            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 67;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 67;
                end
                default:
                begin
                    tx_idle_pct  = 13;
                    rx_stall_pct = 13;
                end
            endcase
            if (phase == 3)
                hold_requests = hold_requests + 1;
            sent = 0;
            while (sent < PhaseItems)
            begin
                if ($urandom_range(9) < 8)
                    len = 2 * $urandom_range(1, 8);
                else
                    len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++)
                    send_sample(rand_sample(), i == len - 1);
                sent = sent + len;
            end
            drain();
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
sv/stbq_pkg.sv
sv/stbq_datapath.sv
sv/stereo_two_biquad_eq.sv
tb/tb_stereo_two_biquad_eq.sv
